/* rtl/core/qsu_pkg.sv */
// ----------------------------------------------------------------------------
// qsu_pkg
// Shared types and byte constants for the quoted-string unescaper.
// ----------------------------------------------------------------------------
`default_nettype none

package qsu_pkg;

    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;

    localparam logic [BYTE_W-1:0] CH_DQUOTE = 8'h22;
    localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_CTLMAX = 8'h1F;
    localparam logic [BYTE_W-1:0] CH_DEL    = 8'h7F;
    localparam logic [BYTE_W-1:0] CH_SP     = 8'h20;
    localparam logic [BYTE_W-1:0] CH_HT     = 8'h09;

    typedef enum logic [STATUS_W-1:0] {
        ST_RUN   = 3'd0,
        ST_OK    = 3'd1,
        ST_NOQ   = 3'd2,
        ST_CTL   = 3'd3,
        ST_FOLD  = 3'd4,
        ST_UNTRM = 3'd5,
        ST_SKIP  = 3'd6
    } status_t;

    typedef enum logic [5:0] {
        MODE_OPEN = 6'b000001,
        MODE_BODY = 6'b000010,
        MODE_ESC  = 6'b000100,
        MODE_CR   = 6'b001000,
        MODE_LF   = 6'b010000,
        MODE_SKIP = 6'b100000
    } mode_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              out_valid;
        logic              finished;
        status_t           status;
    } step_res_t;

endpackage

`default_nettype wire

/* rtl/core/qsu_step.sv */
// ----------------------------------------------------------------------------
// qsu_step
// Judges one byte against the current parse mode: result word and next mode.
// ----------------------------------------------------------------------------
`default_nettype none

module qsu_step
    import qsu_pkg::*;
(
    input  wire mode_t             mode,
    input  wire logic [BYTE_W-1:0] in_byte,
    input  wire logic              last_byte,
    output step_res_t              res,
    output mode_t                  mode_next
);

    logic              valid;
    logic [BYTE_W-1:0] ob;
    status_t           st;
    status_t           st_fin;
    mode_t             nxt;
    logic              is_error;

    always_comb
    begin
        valid = 1'b0;
        ob    = '0;
        st    = ST_RUN;
        nxt   = mode;
        case (mode)
            MODE_SKIP:
            begin
                st = ST_SKIP;
            end
            MODE_BODY:
            begin
                if (in_byte == CH_DQUOTE)
                begin
                    st = ST_OK;
                end
                else if (in_byte == CH_BSLASH)
                begin
                    nxt = MODE_ESC;
                end
                else if (in_byte == CH_CR)
                begin
                    nxt = MODE_CR;
                end
                else if (in_byte == CH_LF)
                begin
                    nxt = MODE_LF;
                end
                else if (in_byte <= CH_CTLMAX || in_byte == CH_DEL)
                begin
                    st = ST_CTL;
                end
                else
                begin
                    valid = 1'b1;
                    ob    = in_byte;
                end
            end
            MODE_ESC:
            begin
                valid = 1'b1;
                ob    = in_byte;
                nxt   = MODE_BODY;
            end
            MODE_CR:
            begin
                if (in_byte == CH_LF)
                begin
                    nxt = MODE_LF;
                end
                else
                begin
                    st = ST_FOLD;
                end
            end
            MODE_LF:
            begin
                // fold: LF + SP/HT collapses to one space
                if (in_byte == CH_SP || in_byte == CH_HT)
                begin
                    valid = 1'b1;
                    ob    = CH_SP;
                    nxt   = MODE_BODY;
                end
                else
                begin
                    st = ST_FOLD;
                end
            end
            default:
            begin
                if (in_byte == CH_DQUOTE)
                begin
                    nxt = MODE_BODY;
                end
                else
                begin
                    st = ST_NOQ;
                end
            end
        endcase

        st_fin = st;
        if (st == ST_RUN && last_byte)
        begin
            st_fin = ST_UNTRM;
        end

        is_error = (st_fin == ST_NOQ) || (st_fin == ST_CTL) ||
                   (st_fin == ST_FOLD) || (st_fin == ST_UNTRM);
        // drop content on any error
        if (is_error)
        begin
            valid = 1'b0;
            ob    = '0;
        end

        if (st_fin != ST_RUN)
        begin
            nxt = last_byte ? MODE_OPEN : MODE_SKIP;
        end

        res.out_byte  = ob;
        res.out_valid = valid;
        res.finished  = (st_fin != ST_RUN) && (st_fin != ST_SKIP);
        res.status    = st_fin;
        mode_next     = nxt;
    end

endmodule

`default_nettype wire

/* rtl/core/quoted_string_unescaper.sv */
// ----------------------------------------------------------------------------
// quoted_string_unescaper
// Checks and unescapes an HTTP quoted-string, one byte per word.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one raw byte of a header field
//   value per word, with last_byte marking the final byte of the field.
//   Result channel (result_valid/result_ready) returns exactly one word per
//   input word: out_byte/out_valid give an unescaped content byte, finished
//   flags the word that ended the string and status gives the outcome.
//   From input acceptance to result valid, a byte passes an input register,
//   then the mode decode, then the result register. Throughput is one byte
//   per clock unless the receiver stalls; the only loop is the parse mode
//   register, which is updated in the same cycle the byte moves into the
//   result register. When the receiver stalls, the result register holds
//   its word while the input register still takes one more byte; in_ready
//   falls once both are full. Reset empties both stages and sets the
//   parser to expect the opening quote of a new field.
// ----------------------------------------------------------------------------
`default_nettype none

module quoted_string_unescaper
    import qsu_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output      logic                in_ready,
    input  wire logic [BYTE_W-1:0]   in_byte,
    input  wire logic                last_byte,
    output      logic                result_valid,
    input  wire logic                result_ready,
    output      logic [BYTE_W-1:0]   out_byte,
    output      logic                out_valid,
    output      logic                finished,
    output      logic [STATUS_W-1:0] status
);

    logic              s1_valid_reg;
    logic [BYTE_W-1:0] s1_byte_reg;
    logic              s1_last_reg;
    mode_t             mode_reg;
    mode_t             mode_next;
    logic              res_valid_reg;
    step_res_t         res_reg;
    step_res_t         res_next;
    logic              out_free;
    logic              s1_move;
    logic              in_take;

    assign out_free = !res_valid_reg || result_ready;
    assign s1_move  = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || s1_move;
    assign in_take  = in_valid && in_ready;

    qsu_step u_step
    (
        .mode      (mode_reg),
        .in_byte   (s1_byte_reg),
        .last_byte (s1_last_reg),
        .res       (res_next),
        .mode_next (mode_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            mode_reg      <= MODE_OPEN;
        end
        else
        begin
            if (in_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_move)
            begin
                res_valid_reg <= 1'b1;
                mode_reg      <= mode_next;
            end
            else if (result_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg <= in_byte;
            s1_last_reg <= last_byte;
        end
        // advance the judged byte into the result register
        if (s1_move)
        begin
            res_reg <= res_next;
        end
    end

    assign result_valid = res_valid_reg;
    assign out_byte     = res_reg.out_byte;
    assign out_valid    = res_reg.out_valid;
    assign finished     = res_reg.finished;
    assign status       = res_reg.status;

endmodule

`default_nettype wire

/* rtl/core/qsu_checker.sv */
// ----------------------------------------------------------------------------
// qsu_checker
// Port-level checks on the result words of the quoted-string unescaper.
// ----------------------------------------------------------------------------
`default_nettype none

module qsu_checker
    import qsu_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                result_valid,
    input wire logic                result_ready,
    input wire logic [BYTE_W-1:0]   out_byte,
    input wire logic                out_valid,
    input wire logic                finished,
    input wire logic [STATUS_W-1:0] status
);

    // content is only carried while the string is still open
    a_content_status: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && out_valid) |-> (status == ST_RUN))
        else $error("content byte on a word that ends or skips");

    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !out_valid) |-> (out_byte == '0))
        else $error("out_byte not cleared without content");

    a_finish_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (finished == ((status != ST_RUN) && (status != ST_SKIP))))
        else $error("finished disagrees with status");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=>
            (result_valid && $stable(out_byte) && $stable(status)))
        else $error("stalled result word changed");

endmodule

bind quoted_string_unescaper qsu_checker u_qsu_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .out_byte     (out_byte),
    .out_valid    (out_valid),
    .finished     (finished),
    .status       (status)
);

`default_nettype wire
